// File: rtl/core/winding_number_point_in_polygon_unit_defines.svh
// Assertion macros for the winding-number point-in-polygon unit.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef WINDING_NUMBER_POINT_IN_POLYGON_UNIT_DEFINES_SVH
`define WINDING_NUMBER_POINT_IN_POLYGON_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define WNPIP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define WNPIP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/wnpip_pkg.sv
// Package of the winding-number point-in-polygon unit: word types, codes,
// states and default sizes. No dependencies.
`default_nettype none

package wnpip_pkg;

  // Default sizes and fixed field widths.
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;
  localparam int FIELD_W          = 16;
  localparam int WIND_W           = 8;
  localparam int MIN_VERTICES     = 3;

  // Command codes carried in the input word.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEST   = 2'd2
  } cmd_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_EDGE,
    S_MUL_A,
    S_MUL_B,
    S_FIN
  } state_e;

  // Input word.
  typedef struct packed {
    logic [1:0]                command;
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic signed [WIND_W-1:0] winding;
    logic                     inside_res;
    logic                     too_few_vertices;
    logic                     vertex_overflow;
  } out_word_t;

endpackage

`default_nettype wire

// File: rtl/core/wnpip_vertex_ram.sv
// Vertex store of the winding-number unit: one write port, one read port
// with registered read data. No dependencies.
`default_nettype none

module wnpip_vertex_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/wnpip_mul_unit.sv
// Shared signed multiplier of the winding-number unit with a registered
// product. No dependencies.
`default_nettype none

module wnpip_mul_unit #(
  parameter int OPW = 17
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [OPW-1:0]   op_a_i,
  input  wire logic signed [OPW-1:0]   op_b_i,
  output logic signed      [2*OPW-1:0] prod_o
);

  // One product per enabled cycle; the result holds otherwise.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o <= op_a_i * op_b_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/winding_number_point_in_polygon_unit.sv
// Top level of the winding-number point-in-polygon unit.
// Depends on wnpip_pkg, wnpip_vertex_ram, wnpip_mul_unit and the defines header.
//
// Usage: a command word is taken on a rising edge with start high and busy low.
// Clear empties the polygon, append stores one vertex (or sets the overflow
// flag when the store is full); both give no result.
// Test walks the polygon and gives one result word, shown on res_o for a
// single cycle with res_valid_o high; the receiver cannot stall it.
// Timing of a test with n stored vertices: with n below three the result
// appears the cycle after acceptance and busy stays low. Otherwise busy is
// high while the polygon is walked; the result appears in the cycle busy falls.
// Each edge passes through EDGE, MUL_A and MUL_B since one multiplier forms
// both cross product terms in turn and the vertex store has a single read port.
// A new command may be taken in the same cycle a result is shown.
// Reset empties the polygon and clears the overflow flag; vertex data is not
// cleared and is only read after being written.
`default_nettype none
`include "winding_number_point_in_polygon_unit_defines.svh"

module winding_number_point_in_polygon_unit #(
  parameter int MAX_VERTICES = wnpip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = wnpip_pkg::COORD_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire wnpip_pkg::in_word_t  word_i,
  output logic                      res_valid_o,
  output wnpip_pkg::out_word_t      res_o
);

  localparam int CW    = (COORD_BITS < wnpip_pkg::FIELD_W) ? COORD_BITS : wnpip_pkg::FIELD_W;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNTW  = $clog2(MAX_VERTICES + 1);
  localparam int WN_W  = CNTW + 1;
  localparam int SW    = (WN_W > wnpip_pkg::WIND_W) ? WN_W : wnpip_pkg::WIND_W;
  localparam logic signed [SW-1:0] W_HI = SW'((2 ** (wnpip_pkg::WIND_W - 1)) - 1);
  localparam logic signed [SW-1:0] W_LO = -W_HI - SW'(1);

  // State and datapath registers.
  wnpip_pkg::state_e state_q, state_d;
  logic [CNTW-1:0]        cnt_q, cnt_d;
  logic                   ovf_q, ovf_d;
  logic [AW-1:0]          idx_q, idx_d;
  logic                   closing_q, closing_d;
  logic                   final_q, final_d;
  logic                   pend_q, pend_d;
  logic signed [WN_W-1:0] wn_q, wn_d;
  logic                   res_valid_q, res_valid_d;
  wnpip_pkg::out_word_t   res_q, res_d;
  logic signed [CW-1:0]   px_q, px_d, py_q, py_d;
  logic signed [CW-1:0]   fx_q, fx_d, fy_q, fy_d;
  logic signed [CW-1:0]   vx_q, vx_d, vy_q, vy_d;
  logic signed [DW-1:0]   dx_q, dx_d, dyp_q, dyp_d, dpx_q, dpx_d, dy_q, dy_d;
  logic                   up_q, up_d, dn_q, dn_d;
  logic signed [PW-1:0]   a_q, a_d;

  // Memory and multiplier connections.
  logic                 we, re;
  logic [AW-1:0]        raddr;
  logic [2*CW-1:0]      rdata;
  logic signed [CW-1:0] rd_x, rd_y;
  logic                 mul_en;
  logic signed [DW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod;

  // Helpers.
  wnpip_pkg::cmd_e      cmd;
  logic signed [CW-1:0] in_x, in_y, ex, ey;
  logic [CNTW-1:0]      cnt_m1;
  logic [AW-1:0]        last_idx;
  logic signed [WN_W-1:0] wn_upd;
  logic signed [SW-1:0] wn_ext, wn_sat;

  assign cmd      = wnpip_pkg::cmd_e'(word_i.command);
  assign in_x     = word_i.point_x[CW-1:0];
  assign in_y     = word_i.point_y[CW-1:0];
  assign rd_x     = rdata[2*CW-1:CW];
  assign rd_y     = rdata[CW-1:0];
  assign cnt_m1   = cnt_q - CNTW'(1);
  assign last_idx = cnt_m1[AW-1:0];
  assign ex       = closing_q ? fx_q : rd_x;
  assign ey       = closing_q ? fy_q : rd_y;

  // Vertex store.
  wnpip_vertex_ram #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (2 * CW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({in_x, in_y}),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Shared multiplier: first term in MUL_A, second term in MUL_B.
  assign op_a = (state_q == wnpip_pkg::S_MUL_A) ? dx_q  : dpx_q;
  assign op_b = (state_q == wnpip_pkg::S_MUL_A) ? dyp_q : dy_q;

  wnpip_mul_unit #(
    .OPW (DW)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  // Apply the pending edge decision: a_q holds the first term, prod the second.
  always_comb begin
    wn_upd = wn_q;
    if (pend_q && up_q && (a_q > prod)) begin
      wn_upd = wn_q + WN_W'(1);
    end else if (pend_q && dn_q && (a_q < prod)) begin
      wn_upd = wn_q - WN_W'(1);
    end
    wn_ext = SW'(wn_upd);
    if (wn_ext > W_HI) begin
      wn_sat = W_HI;
    end else if (wn_ext < W_LO) begin
      wn_sat = W_LO;
    end else begin
      wn_sat = wn_ext;
    end
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    closing_d   = closing_q;
    final_d     = final_q;
    pend_d      = pend_q;
    wn_d        = wn_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    px_d        = px_q;
    py_d        = py_q;
    fx_d        = fx_q;
    fy_d        = fy_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    dx_d        = dx_q;
    dyp_d       = dyp_q;
    dpx_d       = dpx_q;
    dy_d        = dy_q;
    up_d        = up_q;
    dn_d        = dn_q;
    a_d         = a_q;
    we          = 1'b0;
    re          = 1'b0;
    raddr       = '0;
    mul_en      = 1'b0;

    case (state_q)
      wnpip_pkg::S_IDLE: begin
        if (start) begin
          case (cmd)
            wnpip_pkg::CMD_CLEAR: begin
              cnt_d = '0;
              ovf_d = 1'b0;
            end
            wnpip_pkg::CMD_APPEND: begin
              if (cnt_q < CNTW'(MAX_VERTICES)) begin
                we    = 1'b1;
                cnt_d = cnt_q + CNTW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            wnpip_pkg::CMD_TEST: begin
              if (cnt_q < CNTW'(wnpip_pkg::MIN_VERTICES)) begin
                res_valid_d            = 1'b1;
                res_d.winding          = '0;
                res_d.inside_res       = 1'b0;
                res_d.too_few_vertices = 1'b1;
                res_d.vertex_overflow  = ovf_q;
              end else begin
                px_d      = in_x;
                py_d      = in_y;
                re        = 1'b1;
                raddr     = '0;
                idx_d     = '0;
                wn_d      = '0;
                pend_d    = 1'b0;
                closing_d = 1'b0;
                final_d   = 1'b0;
                state_d   = wnpip_pkg::S_FIRST;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // First vertex arrives: keep it for the closing edge.
      wnpip_pkg::S_FIRST: begin
        fx_d    = rd_x;
        fy_d    = rd_y;
        vx_d    = rd_x;
        vy_d    = rd_y;
        re      = 1'b1;
        raddr   = AW'(1);
        idx_d   = AW'(1);
        state_d = wnpip_pkg::S_EDGE;
      end

      // Set up one edge from the previous vertex to the current end vertex,
      // retire the decision of the edge before it and fetch the next vertex if any.
      wnpip_pkg::S_EDGE: begin
        dx_d   = {ex[CW-1], ex} - {vx_q[CW-1], vx_q};
        dyp_d  = {py_q[CW-1], py_q} - {vy_q[CW-1], vy_q};
        dpx_d  = {px_q[CW-1], px_q} - {vx_q[CW-1], vx_q};
        dy_d   = {ey[CW-1], ey} - {vy_q[CW-1], vy_q};
        up_d   = (vy_q <= py_q) && (ey > py_q);
        dn_d   = (vy_q > py_q) && (ey <= py_q);
        vx_d   = ex;
        vy_d   = ey;
        wn_d   = wn_upd;
        pend_d = 1'b0;
        if (closing_q) begin
          final_d = 1'b1;
        end else if (idx_q == last_idx) begin
          closing_d = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = idx_q + AW'(1);
          idx_d = idx_q + AW'(1);
        end
        state_d = wnpip_pkg::S_MUL_A;
      end

      wnpip_pkg::S_MUL_A: begin
        mul_en  = 1'b1;
        state_d = wnpip_pkg::S_MUL_B;
      end

      wnpip_pkg::S_MUL_B: begin
        mul_en  = 1'b1;
        a_d     = prod;
        pend_d  = 1'b1;
        state_d = final_q ? wnpip_pkg::S_FIN : wnpip_pkg::S_EDGE;
      end

      // Retire the closing edge and present the result.
      wnpip_pkg::S_FIN: begin
        wn_d                   = wn_upd;
        pend_d                 = 1'b0;
        res_valid_d            = 1'b1;
        res_d.winding          = wn_sat[wnpip_pkg::WIND_W-1:0];
        res_d.inside_res       = (wn_upd != '0);
        res_d.too_few_vertices = 1'b0;
        res_d.vertex_overflow  = ovf_q;
        state_d                = wnpip_pkg::S_IDLE;
      end

      default: begin
        state_d = wnpip_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wnpip_pkg::S_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      closing_q   <= 1'b0;
      final_q     <= 1'b0;
      pend_q      <= 1'b0;
      wn_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      idx_q       <= idx_d;
      closing_q   <= closing_d;
      final_q     <= final_d;
      pend_q      <= pend_d;
      wn_q        <= wn_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    px_q  <= px_d;
    py_q  <= py_d;
    fx_q  <= fx_d;
    fy_q  <= fy_d;
    vx_q  <= vx_d;
    vy_q  <= vy_d;
    dx_q  <= dx_d;
    dyp_q <= dyp_d;
    dpx_q <= dpx_d;
    dy_q  <= dy_d;
    up_q  <= up_d;
    dn_q  <= dn_d;
    a_q   <= a_d;
  end

  assign busy        = (state_q != wnpip_pkg::S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Terms used by the checks below.
  logic walk_ok, inside_ok, few_res;
  assign walk_ok   = (cnt_q >= CNTW'(wnpip_pkg::MIN_VERTICES)) && (idx_q <= last_idx);
  assign inside_ok = (res_o.inside_res == (res_o.winding != '0));
  assign few_res   = res_valid_o && res_o.too_few_vertices;

  // Checks on the sequencer and the result word.
  `WNPIP_ASSERT_NEXT(a_fin_gives_result, state_q == wnpip_pkg::S_FIN, res_valid_o, "lost result")
  `WNPIP_ASSERT_NOW(a_walk_needs_polygon, busy, walk_ok, "walk past the polygon")
  `WNPIP_ASSERT_NOW(a_inside_matches, res_valid_o, inside_ok, "inside flag mismatch")
  `WNPIP_ASSERT_NOW(a_few_gives_zero, few_res, res_o.winding == '0, "nonzero winding")

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for winding_number_point_in_polygon_unit: a directed table, then random
// polygon loads and probes, each result checked against a local model or a pinned word.
// Depends on wnpip_pkg and the unit's RTL only.

module tb_top;

  localparam int POLY_CAP     = wnpip_pkg::MAX_VERTICES_DEF;
  localparam int RANDOM_WORDS = 1500;
  localparam int CYCLE_LIMIT  = 2_000_000;
  // Drain margin sized from the longest probe, which walks a full store.
  localparam int DRAIN_CYCLES = 3 * POLY_CAP + 20;
  localparam int N_DIR        = 25;
  localparam int FW           = wnpip_pkg::FIELD_W;

  // The one command code the unit does not define.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // Result words that can be read straight off the behavior.
  localparam wnpip_pkg::out_word_t RES_FEW = '{winding: '0, inside_res: 1'b0,
                                    too_few_vertices: 1'b1, vertex_overflow: 1'b0};
  localparam wnpip_pkg::out_word_t RES_FLAT_OVF = '{winding: '0, inside_res: 1'b0,
                                         too_few_vertices: 1'b0, vertex_overflow: 1'b1};

  typedef enum logic {CHK_MODEL, CHK_FIXED} chk_e;
  typedef enum int {SPAN_TINY, SPAN_MID, SPAN_FULL, SPAN_EDGE} span_e;

  typedef struct {
    wnpip_pkg::in_word_t  word;
    int                   reps;
    chk_e                 chk;
    wnpip_pkg::out_word_t pinned_res;
  } dir_row_t;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start  = 1'b0;
  wnpip_pkg::in_word_t  word_i = '0;
  logic                 busy;
  logic                 res_valid_o;
  wnpip_pkg::out_word_t res_o;

  winding_number_point_in_polygon_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .word_i     (word_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Local copy of the polygon store.
  logic signed [FW-1:0] poly_x [POLY_CAP];
  logic signed [FW-1:0] poly_y [POLY_CAP];
  int unsigned poly_len      = 0;
  bit          poly_overflow = 1'b0;

  wnpip_pkg::out_word_t probe_results_q [$];
  bit                   pin_valid = 1'b0;
  wnpip_pkg::out_word_t pin_word  = '0;
  int        idle_pct  = 0;
  int        n_sent = 0, n_accepted = 0, n_checked = 0, n_errors = 0;
  int        n_inside = 0, n_few = 0, n_ovf = 0;
  int unsigned cycle_count = 0;

  // Applies one command word to the polygon copy; returns 1 with the probe result
  // when the word is a probe.
  function automatic bit polygon_step(input wnpip_pkg::in_word_t w,
                                      output wnpip_pkg::out_word_t r);
    longint      px, py, x0, y0, x1, y1, lhs, rhs;
    int          wn;
    int unsigned i, j;
    r  = '0;
    px = w.point_x;
    py = w.point_y;
    case (w.command)
      wnpip_pkg::CMD_CLEAR: begin
        poly_len      = 0;
        poly_overflow = 1'b0;
        return 1'b0;
      end
      wnpip_pkg::CMD_APPEND: begin
        if (poly_len < POLY_CAP) begin
          poly_x[poly_len] = w.point_x;
          poly_y[poly_len] = w.point_y;
          poly_len++;
        end else begin
          poly_overflow = 1'b1;
        end
        return 1'b0;
      end
      wnpip_pkg::CMD_TEST: begin
        wn = 0;
        if (poly_len >= wnpip_pkg::MIN_VERTICES) begin
          for (i = 0; i < poly_len; i++) begin
            // The last edge closes the polygon back to the first vertex.
            j   = (i + 1 < poly_len) ? i + 1 : 0;
            x0  = poly_x[i];
            y0  = poly_y[i];
            x1  = poly_x[j];
            y1  = poly_y[j];
            lhs = (x1 - x0) * (py - y0);
            rhs = (px - x0) * (y1 - y0);
            if (y0 <= py) begin
              if (y1 > py && lhs > rhs) wn++;
            end else if (y1 <= py && lhs < rhs) begin
              wn--;
            end
          end
        end
        if (wn > 127) wn = 127;
        if (wn < -128) wn = -128;
        r.winding          = wn[wnpip_pkg::WIND_W-1:0];
        r.inside_res       = (wn != 0);
        r.too_few_vertices = (poly_len < wnpip_pkg::MIN_VERTICES);
        r.vertex_overflow  = poly_overflow;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic wnpip_pkg::in_word_t mk_word(input logic [1:0] cmd,
                                                  input logic signed [FW-1:0] x,
                                                  input logic signed [FW-1:0] y);
    wnpip_pkg::in_word_t w;
    w.command = cmd;
    w.point_x = x;
    w.point_y = y;
    return w;
  endfunction

  function automatic dir_row_t row(input logic [1:0] cmd, input int x, input int y,
                                   input int reps = 1, input chk_e chk = CHK_MODEL,
                                   input wnpip_pkg::out_word_t pinned_res = '0);
    dir_row_t d;
    d.word       = mk_word(cmd, x[FW-1:0], y[FW-1:0]);
    d.reps       = reps;
    d.chk        = chk;
    d.pinned_res = pinned_res;
    return d;
  endfunction

  // Random coordinate; the tiny span makes shared rows, vertices and edges likely.
  function automatic logic signed [FW-1:0] rand_coord(input span_e span);
    int v;
    case (span)
      SPAN_TINY: v = int'($urandom_range(40)) - 20;
      SPAN_MID:  v = int'($urandom_range(4000)) - 2000;
      SPAN_FULL: v = int'($urandom);
      default: begin
        case ($urandom_range(3))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = 0;
          default: v = -1;
        endcase
      end
    endcase
    return v[FW-1:0];
  endfunction

  // Presents one word after a random idle stretch and holds it until it is taken.
  task automatic send_word(input wnpip_pkg::in_word_t w, input bit pinned = 1'b0,
                           input wnpip_pkg::out_word_t pinned_res = '0);
    pin_valid = pinned;
    pin_word  = pinned_res;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start  <= 1'b1;
    word_i <= w;
    if (w.command != CMD_SPARE) n_sent++;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Checks each result word against the oldest expectation, then records a newly
  // accepted word in the polygon copy.
  always @(posedge clk_i) begin
    wnpip_pkg::out_word_t exp_w, pred_w;
    if (rst_ni && res_valid_o) begin
      if (probe_results_q.size() == 0) begin
        n_errors++;
        $error("result word with no probe pending: %p", res_o);
      end else begin
        exp_w = probe_results_q.pop_front();
        n_checked++;
        if (res_o.winding !== exp_w.winding) begin
          n_errors++;
          $error("winding: expected %0d, got %0d", exp_w.winding, res_o.winding);
        end
        if (res_o.inside_res !== exp_w.inside_res) begin
          n_errors++;
          $error("inside_res: expected %0b, got %0b", exp_w.inside_res, res_o.inside_res);
        end
        if (res_o.too_few_vertices !== exp_w.too_few_vertices) begin
          n_errors++;
          $error("too_few_vertices: expected %0b, got %0b",
                 exp_w.too_few_vertices, res_o.too_few_vertices);
        end
        if (res_o.vertex_overflow !== exp_w.vertex_overflow) begin
          n_errors++;
          $error("vertex_overflow: expected %0b, got %0b",
                 exp_w.vertex_overflow, res_o.vertex_overflow);
        end
        if (res_o.inside_res === 1'b1) n_inside++;
        if (res_o.too_few_vertices === 1'b1) n_few++;
        if (res_o.vertex_overflow === 1'b1) n_ovf++;
      end
    end
    if (rst_ni && start && !busy) begin
      n_accepted++;
      if (polygon_step(word_i, pred_w))
        probe_results_q.push_back(pin_valid ? pin_word : pred_w);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d probe results still pending.",
               cycle_count, probe_results_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus: directed table, then three random phases with different sender idling.
  initial begin
    dir_row_t             dir_table [N_DIR];
    logic signed [FW-1:0] hist_x [$];
    logic signed [FW-1:0] hist_y [$];
    logic signed [FW-1:0] x, y;
    span_e                span;
    int                   k, r, ph, pick, nv, np, target;

    dir_table = '{
      row(wnpip_pkg::CMD_TEST,   0, 0, 1, CHK_FIXED, RES_FEW),   // empty polygon out of reset
      row(CMD_SPARE,             -1, -1),                        // undefined command, all ones
      row(wnpip_pkg::CMD_APPEND, -32768, -32768),
      row(wnpip_pkg::CMD_APPEND, 32767, -32768),
      row(wnpip_pkg::CMD_TEST,   0, 0, 1, CHK_FIXED, RES_FEW),   // two vertices only
      row(wnpip_pkg::CMD_APPEND, 32767, 32767),
      row(wnpip_pkg::CMD_TEST,   0, 0),                          // smallest polygon
      row(wnpip_pkg::CMD_APPEND, -32768, 32767),
      row(wnpip_pkg::CMD_TEST,   0, 0),                          // counterclockwise square
      row(wnpip_pkg::CMD_TEST,   -32768, -32768),
      row(wnpip_pkg::CMD_TEST,   32767, 32767),
      row(wnpip_pkg::CMD_TEST,   0, -32768),                     // on the bottom edge
      row(wnpip_pkg::CMD_TEST,   -32768, 0),                     // on the left edge
      row(wnpip_pkg::CMD_CLEAR,  0, 0),
      row(wnpip_pkg::CMD_APPEND, 0, 0),
      row(wnpip_pkg::CMD_APPEND, 0, 10),
      row(wnpip_pkg::CMD_APPEND, 10, 0),
      row(wnpip_pkg::CMD_TEST,   2, 2),                          // clockwise triangle
      row(wnpip_pkg::CMD_TEST,   0, 5),                          // on an upward edge
      row(wnpip_pkg::CMD_TEST,   20, 20),                        // outside
      row(wnpip_pkg::CMD_CLEAR,  0, 0),
      row(wnpip_pkg::CMD_APPEND, 5, 5, POLY_CAP + 1),            // one append past a full store
      row(wnpip_pkg::CMD_TEST,   5, 5, 1, CHK_FIXED, RES_FLAT_OVF),
      row(wnpip_pkg::CMD_CLEAR,  0, 0),
      row(wnpip_pkg::CMD_TEST,   0, 0, 1, CHK_FIXED, RES_FEW)    // clear drops overflow flag
    };

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_table[i])
      for (r = 0; r < dir_table[i].reps; r++)
        send_word(dir_table[i].word, dir_table[i].chk == CHK_FIXED,
                  dir_table[i].pinned_res);

    for (ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 10 : (ph == 1) ? 86 : 0;
      target   = n_sent + RANDOM_WORDS / 3;
      while (n_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          // Well-formed: clear, load a polygon, probe it a few times.
          span = span_e'($urandom_range(3));
          send_word(mk_word(wnpip_pkg::CMD_CLEAR, rand_coord(SPAN_FULL),
                            rand_coord(SPAN_FULL)));
          hist_x.delete();
          hist_y.delete();
          pick = $urandom_range(99);
          nv = (pick < 8) ? $urandom_range(2) :
               (pick < 95) ? $urandom_range(12, 3) : $urandom_range(70, 60);
          repeat (nv) begin
            x = rand_coord(span);
            y = rand_coord(span);
            hist_x.push_back(x);
            hist_y.push_back(y);
            send_word(mk_word(wnpip_pkg::CMD_APPEND, x, y));
          end
          np = $urandom_range(6, 1);
          repeat (np) begin
            k = $urandom_range(3);
            if (k == 0 && hist_x.size() > 0) begin
              // Probe right on a vertex, or on its row.
              k = $urandom_range(hist_x.size() - 1);
              x = $urandom_range(1) ? hist_x[k] : rand_coord(span);
              y = hist_y[k];
            end else begin
              x = rand_coord(span);
              y = rand_coord(span);
            end
            send_word(mk_word(wnpip_pkg::CMD_TEST, x, y));
          end
        end else if (pick < 90) begin
          // Noise: any command, any bits.
          send_word(mk_word(2'($urandom_range(3)), rand_coord(SPAN_FULL),
                            rand_coord(SPAN_FULL)));
        end else begin
          // Broken sequence: appends onto whatever is stored, then a probe.
          repeat ($urandom_range(4, 1))
            send_word(mk_word(wnpip_pkg::CMD_APPEND, rand_coord(SPAN_MID),
                              rand_coord(SPAN_MID)));
          send_word(mk_word(wnpip_pkg::CMD_TEST, rand_coord(SPAN_MID), rand_coord(SPAN_MID)));
        end
      end
    end

    start <= 1'b0;
    while (probe_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d accepted words and %0d checked probe results", n_accepted,
             n_checked);
    $display("(%0d inside, %0d with too few vertices, %0d after a store overflow).",
             n_inside, n_few, n_ovf);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
